/* sv/vsrm_pkg.sv */
// ----------------------------------------------------------------------------
// vsrm_pkg
// shared types and constants for the versioned sorted run merge
// ----------------------------------------------------------------------------
package vsrm_pkg;

  localparam int RUN_CAPACITY_DEF = 32;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int KEY_W     = 32;
  localparam int VAL_MAX_W = 64;
  localparam int VER_W     = 32;
  localparam int ST_W      = 3;
  localparam int CNT_W     = 6;
  localparam int MODE_W    = 2;

  localparam int REC_FIX_W = KEY_W + VER_W + ST_W;
  localparam int SUM_W     = 2 * KEY_W + 2 * CNT_W;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

  localparam logic [ST_W-1:0]  ST_TOMBSTONE = 3'b111;
  localparam logic [KEY_W-1:0] KEY_MAX      = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_MIN      = 32'h8000_0000;

  typedef struct packed {
    logic [ST_W-1:0]      st;
    logic [VER_W-1:0]     ver;
    logic [VAL_MAX_W-1:0] val;
    logic [KEY_W-1:0]     key;
  } rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] tomb;
    logic [CNT_W-1:0] cnt;
    logic [KEY_W-1:0] mx;
    logic [KEY_W-1:0] mn;
  } stats_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic close;
  } stats_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_PICK,
    S_FLUSH,
    S_EMPTY
  } state_t;

endpackage

/* sv/versioned_sorted_run_merge.sv */
// ----------------------------------------------------------------------------
// versioned_sorted_run_merge
// two-way merge of key-sorted versioned runs with duplicate removal
// load item: one load per cycle while no merge runs
// merge item: each stored record takes a registered memory read, then the
//   shared key compare; the last record goes out from S_FLUSH, and an empty
//   merge sends a single marker item; the steps wait while the output stalls
// the block takes no item while a merge runs; its last result may still wait
// reset: synchronous, empties both runs and the output register
// ----------------------------------------------------------------------------
module versioned_sorted_run_merge #(
  parameter int RUN_CAPACITY = vsrm_pkg::RUN_CAPACITY_DEF,
  parameter int PAYLOAD_BITS = vsrm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // rec_key, rec_value, rec_version, rec_state, zero pad
  input  logic [(vsrm_pkg::REC_FIX_W + PAYLOAD_BITS + 7) / 8 * 8 - 1:0] s_tdata,
  // mode
  input  logic [vsrm_pkg::MODE_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_key, out_value, out_version, out_state, table_min_key,
  // table_max_key, table_count, table_tombstones, zero pad
  output logic [(vsrm_pkg::REC_FIX_W + vsrm_pkg::SUM_W + PAYLOAD_BITS + 7) / 8 * 8 - 1:0]
               m_tdata,
  // out_table, table_end
  output logic [1:0] m_tuser,
  // merge_end
  output logic m_tlast
);

  localparam int KW_   = vsrm_pkg::KEY_W;
  localparam int CW    = $clog2(RUN_CAPACITY + 1);
  localparam int KW    = $clog2(2 * RUN_CAPACITY);
  localparam int O_VAL = KW_;
  localparam int O_VER = O_VAL + PAYLOAD_BITS;
  localparam int O_ST  = O_VER + vsrm_pkg::VER_W;
  localparam int O_SUM = O_ST + vsrm_pkg::ST_W;

  vsrm_pkg::state_t state, state_next;
  logic [CW-1:0]    ia, ia_next, ib, ib_next;
  logic [KW-1:0]    k, k_next;
  vsrm_pkg::rec_t   pend, pend_next;
  logic             pend_valid, pend_valid_next;

  vsrm_pkg::rec_t   in_rec, a_rec, b_rec, pick;
  logic [CW-1:0]    a_count, b_count;
  logic             load_a, load_b, runs_clear;
  logic             a_has, b_has, take_a, out_free;
  logic             emit, emit_last, emit_marker, tend_c, table_c;

  vsrm_pkg::stats_ctrl_t sctrl;
  vsrm_pkg::stats_t      incl;

  vsrm_pkg::rec_t   o_rec;
  vsrm_pkg::stats_t o_sum;
  logic             o_table, o_tend, o_mend;

  always_comb begin
    in_rec     = '0;
    in_rec.key = s_tdata[KW_-1:0];
    in_rec.val[PAYLOAD_BITS-1:0] = s_tdata[O_VAL +: PAYLOAD_BITS];
    in_rec.ver = s_tdata[O_VER +: vsrm_pkg::VER_W];
    in_rec.st  = s_tdata[O_ST +: vsrm_pkg::ST_W];
  end

  vsrm_run_store #(.RUN_CAPACITY(RUN_CAPACITY)) u_run_a (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (load_a),
    .wr_rec (in_rec),
    .clear  (runs_clear),
    .rd_idx (ia),
    .rd_rec (a_rec),
    .count  (a_count)
  );

  vsrm_run_store #(.RUN_CAPACITY(RUN_CAPACITY)) u_run_b (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (load_b),
    .wr_rec (in_rec),
    .clear  (runs_clear),
    .rd_idx (ib),
    .rd_rec (b_rec),
    .count  (b_count)
  );

  vsrm_table_stats u_stats (
    .clk  (clk),
    .rst  (rst),
    .ctrl (sctrl),
    .key  (pend.key),
    .st   (pend.st),
    .incl (incl)
  );

  assign s_tready = (state == vsrm_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign a_has    = (ia < a_count);
  assign b_has    = (ib < b_count);
  // run a wins on equal keys
  assign take_a   = a_has && (!b_has || ($signed(a_rec.key) <= $signed(b_rec.key)));
  assign pick     = take_a ? a_rec : b_rec;

  assign tend_c  = emit_marker || emit_last || (k == KW'(RUN_CAPACITY - 1));
  assign table_c = !emit_marker && (k >= KW'(RUN_CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vsrm_pkg::S_IDLE;
      pend_valid <= 1'b0;
      ia         <= '0;
      ib         <= '0;
      k          <= '0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      ia         <= ia_next;
      ib         <= ib_next;
      k          <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  always_comb begin
    state_next      = state;
    ia_next         = ia;
    ib_next         = ib;
    k_next          = k;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    load_a          = 1'b0;
    load_b          = 1'b0;
    runs_clear      = 1'b0;
    emit            = 1'b0;
    emit_last       = 1'b0;
    emit_marker     = 1'b0;
    sctrl           = '0;

    case (state)
      vsrm_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            vsrm_pkg::MODE_LOAD_A: load_a = 1'b1;
            vsrm_pkg::MODE_LOAD_B: load_b = 1'b1;
            vsrm_pkg::MODE_MERGE: begin
              ia_next         = '0;
              ib_next         = '0;
              k_next          = '0;
              pend_valid_next = 1'b0;
              sctrl.clear     = 1'b1;
              if (a_count == '0 && b_count == '0) begin
                state_next = vsrm_pkg::S_EMPTY;
              end else begin
                state_next = vsrm_pkg::S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      vsrm_pkg::S_FETCH: begin
        state_next = vsrm_pkg::S_PICK;
      end

      vsrm_pkg::S_PICK: begin
        if (!a_has && !b_has) begin
          state_next = vsrm_pkg::S_FLUSH;
        end else if (!pend_valid || pick.key == pend.key || out_free) begin
          if (!pend_valid) begin
            pend_next       = pick;
            pend_valid_next = 1'b1;
          end else if (pick.key == pend.key) begin
            // later duplicate replaces only with a strictly newer version
            if (pick.ver > pend.ver) begin
              pend_next = pick;
            end
          end else begin
            emit      = 1'b1;
            pend_next = pick;
          end
          if (take_a) begin
            ia_next = ia + CW'(1);
          end else begin
            ib_next = ib + CW'(1);
          end
          state_next = vsrm_pkg::S_FETCH;
        end
      end

      vsrm_pkg::S_FLUSH: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_last       = 1'b1;
          runs_clear      = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = vsrm_pkg::S_IDLE;
        end
      end

      vsrm_pkg::S_EMPTY: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_marker = 1'b1;
          state_next  = vsrm_pkg::S_IDLE;
        end
      end

      default: state_next = vsrm_pkg::S_IDLE;
    endcase

    if (emit && !emit_marker) begin
      k_next      = k + KW'(1);
      sctrl.take  = 1'b1;
      sctrl.close = tend_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_rec   <= emit_marker ? '0 : pend;
      o_table <= table_c;
      o_tend  <= tend_c;
      o_mend  <= emit_last || emit_marker;
      if (emit_marker) begin
        o_sum.mn   <= vsrm_pkg::KEY_MAX;
        o_sum.mx   <= vsrm_pkg::KEY_MIN;
        o_sum.cnt  <= '0;
        o_sum.tomb <= '0;
      end else if (tend_c) begin
        o_sum <= incl;
      end else begin
        o_sum <= '0;
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[KW_-1:0]                  = o_rec.key;
    m_tdata[O_VAL +: PAYLOAD_BITS]    = o_rec.val[PAYLOAD_BITS-1:0];
    m_tdata[O_VER +: vsrm_pkg::VER_W] = o_rec.ver;
    m_tdata[O_ST +: vsrm_pkg::ST_W]   = o_rec.st;
    m_tdata[O_SUM +: vsrm_pkg::SUM_W] = o_sum;
  end

  assign m_tuser = {o_tend, o_table};
  assign m_tlast = o_mend;

endmodule

/* sv/vsrm_run_store.sv */
// ----------------------------------------------------------------------------
// vsrm_run_store
// one sorted run: record memory with fill count and registered read port
// ----------------------------------------------------------------------------
module vsrm_run_store #(
  parameter int RUN_CAPACITY = vsrm_pkg::RUN_CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  vsrm_pkg::rec_t                    wr_rec,
  input  logic                              clear,
  input  logic [$clog2(RUN_CAPACITY+1)-1:0] rd_idx,
  output vsrm_pkg::rec_t                    rd_rec,
  output logic [$clog2(RUN_CAPACITY+1)-1:0] count
);

  localparam int CW = $clog2(RUN_CAPACITY + 1);
  localparam int AW = (RUN_CAPACITY > 1) ? $clog2(RUN_CAPACITY) : 1;

  vsrm_pkg::rec_t mem [RUN_CAPACITY];

  logic full;
  assign full = (count == CW'(RUN_CAPACITY));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (wr_en && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[count[AW-1:0]] <= wr_rec;
    end
    rd_rec <= mem[rd_idx[AW-1:0]];
  end

endmodule

/* sv/vsrm_table_stats.sv */
// ----------------------------------------------------------------------------
// vsrm_table_stats
// running min, max, count and tombstone count of the table being emitted
// ----------------------------------------------------------------------------
module vsrm_table_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  vsrm_pkg::stats_ctrl_t         ctrl,
  input  logic [vsrm_pkg::KEY_W-1:0]    key,
  input  logic [vsrm_pkg::ST_W-1:0]     st,
  output vsrm_pkg::stats_t              incl
);

  vsrm_pkg::stats_t acc;
  vsrm_pkg::stats_t sentinel;

  always_comb begin
    sentinel.mn   = vsrm_pkg::KEY_MAX;
    sentinel.mx   = vsrm_pkg::KEY_MIN;
    sentinel.cnt  = '0;
    sentinel.tomb = '0;
  end

  // stats with the current item folded in
  always_comb begin
    incl.mn   = ($signed(key) < $signed(acc.mn)) ? key : acc.mn;
    incl.mx   = ($signed(acc.mx) < $signed(key)) ? key : acc.mx;
    incl.cnt  = acc.cnt + vsrm_pkg::CNT_W'(1);
    incl.tomb = acc.tomb + vsrm_pkg::CNT_W'(st == vsrm_pkg::ST_TOMBSTONE);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= sentinel;
    end else if (ctrl.take) begin
      acc <= ctrl.close ? sentinel : incl;
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks versioned_sorted_run_merge: loads records into the two runs, issues
// merge commands and compares every merged item against a behavioral
// compaction model (key interleave, version-based duplicate removal, split
// into two tables with per-table summaries), under random source gaps and
// sink stalls
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP      = vsrm_pkg::RUN_CAPACITY_DEF;
  localparam int PAY_W    = vsrm_pkg::PAYLOAD_BITS_DEF;
  localparam int S_W      = (vsrm_pkg::REC_FIX_W + PAY_W + 7) / 8 * 8;
  localparam int M_W      = (vsrm_pkg::REC_FIX_W + vsrm_pkg::SUM_W + PAY_W + 7) / 8 * 8;
  localparam int REC_W    = $bits(vsrm_pkg::rec_t);
  localparam int TARGET   = 230;

  localparam logic [vsrm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [vsrm_pkg::ST_W-1:0]   ST_NONE     = 3'd0;
  localparam logic [vsrm_pkg::ST_W-1:0]   ST_UPDATED  = 3'd1;
  localparam logic [vsrm_pkg::ST_W-1:0]   ST_INSERTED = 3'd2;

  typedef struct packed {
    logic [vsrm_pkg::MODE_W-1:0] mode;
    vsrm_pkg::rec_t              rec;
  } cmd_t;

  typedef struct packed {
    vsrm_pkg::rec_t   rec;
    vsrm_pkg::stats_t sum;
    logic             tbl;
    logic             tend;
    logic             mend;
  } merge_out_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [S_W-1:0]              s_tdata = '0;
  logic [vsrm_pkg::MODE_W-1:0] s_tuser = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [M_W-1:0]              m_tdata;
  logic [1:0]                  m_tuser;
  logic                        m_tlast;

  versioned_sorted_run_merge u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  cmd_t           cmd_q[$];
  merge_out_t     merge_results_q[$];
  vsrm_pkg::rec_t run_a_recs[$];
  vsrm_pkg::rec_t run_b_recs[$];

  int cmds_taken = 0;
  int merges_done = 0;
  int items_checked = 0;
  int spill_items = 0;
  int bad = 0;

  function automatic void queue_cmd(logic [vsrm_pkg::MODE_W-1:0] mode,
                                    logic [vsrm_pkg::KEY_W-1:0] key,
                                    logic [vsrm_pkg::VAL_MAX_W-1:0] val,
                                    logic [vsrm_pkg::VER_W-1:0] ver,
                                    logic [vsrm_pkg::ST_W-1:0] st);
    cmd_t c;
    c.mode    = mode;
    c.rec.key = key;
    c.rec.val = val;
    c.rec.ver = ver;
    c.rec.st  = st;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic logic [vsrm_pkg::VAL_MAX_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [vsrm_pkg::VER_W-1:0] rand_ver();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [vsrm_pkg::ST_W-1:0] rand_st();
    case ($urandom_range(0, 3))
      0:       return vsrm_pkg::ST_TOMBSTONE;
      1:       return ST_NONE;
      2:       return ST_UPDATED;
      default: return ST_INSERTED;
    endcase
  endfunction

  // run bookkeeping and compaction of both runs on a merge
  function automatic void absorb_cmd(cmd_t c);
    vsrm_pkg::rec_t   mrg[$];
    vsrm_pkg::rec_t   keep[$];
    vsrm_pkg::stats_t sum[2];
    merge_out_t       r;
    int               ia;
    int               ib;
    int               tsel;
    case (c.mode)
      vsrm_pkg::MODE_LOAD_A:
        if (run_a_recs.size() < CAP) run_a_recs.insert(run_a_recs.size(), c.rec);
      vsrm_pkg::MODE_LOAD_B:
        if (run_b_recs.size() < CAP) run_b_recs.insert(run_b_recs.size(), c.rec);
      vsrm_pkg::MODE_MERGE: begin
        merges_done++;
        if (run_a_recs.size() == 0 && run_b_recs.size() == 0) begin
          r        = '0;
          r.sum.mn = vsrm_pkg::KEY_MAX;
          r.sum.mx = vsrm_pkg::KEY_MIN;
          r.tend   = 1'b1;
          r.mend   = 1'b1;
          merge_results_q.insert(merge_results_q.size(), r);
        end else begin
          ia = 0;
          ib = 0;
          while (ia < run_a_recs.size() && ib < run_b_recs.size()) begin
            if ($signed(run_a_recs[ia].key) <= $signed(run_b_recs[ib].key)) begin
              mrg.insert(mrg.size(), run_a_recs[ia]);
              ia++;
            end else begin
              mrg.insert(mrg.size(), run_b_recs[ib]);
              ib++;
            end
          end
          while (ia < run_a_recs.size()) begin
            mrg.insert(mrg.size(), run_a_recs[ia]);
            ia++;
          end
          while (ib < run_b_recs.size()) begin
            mrg.insert(mrg.size(), run_b_recs[ib]);
            ib++;
          end
          foreach (mrg[i]) begin
            if (keep.size() == 0 || mrg[i].key != keep[keep.size()-1].key)
              keep.insert(keep.size(), mrg[i]);
            else if (mrg[i].ver > keep[keep.size()-1].ver)
              keep[keep.size()-1] = mrg[i];
          end
          for (int t = 0; t < 2; t++) begin
            sum[t].mn   = vsrm_pkg::KEY_MAX;
            sum[t].mx   = vsrm_pkg::KEY_MIN;
            sum[t].cnt  = '0;
            sum[t].tomb = '0;
          end
          foreach (keep[i]) begin
            tsel = (i < CAP) ? 0 : 1;
            if ($signed(keep[i].key) > $signed(sum[tsel].mx)) sum[tsel].mx = keep[i].key;
            if ($signed(keep[i].key) < $signed(sum[tsel].mn)) sum[tsel].mn = keep[i].key;
            sum[tsel].cnt++;
            if (keep[i].st == vsrm_pkg::ST_TOMBSTONE) sum[tsel].tomb++;
          end
          foreach (keep[i]) begin
            tsel   = (i < CAP) ? 0 : 1;
            r.rec  = keep[i];
            r.tbl  = tsel[0];
            r.tend = (i == CAP - 1) || (i == keep.size() - 1);
            r.mend = (i == keep.size() - 1);
            r.sum  = r.tend ? sum[tsel] : '0;
            merge_results_q.insert(merge_results_q.size(), r);
          end
          run_a_recs.delete();
          run_b_recs.delete();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void show_item(string tag, merge_out_t r);
    $display("  %s key %h val %h ver %h st %h table %b end %b last %b", tag,
             r.rec.key, r.rec.val, r.rec.ver, r.rec.st, r.tbl, r.tend, r.mend);
    $display("  %s min %h max %h cnt %0d tomb %0d", tag,
             r.sum.mn, r.sum.mx, r.sum.cnt, r.sum.tomb);
  endfunction

  // source: bursts with random gaps, valid held until taken
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      gap_left   <= 0;
      burst_left <= $urandom_range(1, 24);
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_cmd(cmd_q.pop_front());
        cmds_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= S_W'(cmd_q[0].rec);
          s_tuser  <= cmd_q[0].mode;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink: random stall pattern, chosen anew each time sink_cyc[6:0] is zero
  logic [15:0] sink_cyc = '0;
  logic [1:0]  sink_mode = '0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_cyc  <= '0;
      sink_mode <= '0;
    end else begin
      sink_cyc <= sink_cyc + 16'd1;
      if (sink_cyc[6:0] == 7'd0) sink_mode <= 2'($urandom_range(0, 3));
      case (sink_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
        2'd2:    m_tready <= (sink_cyc[2:0] == 3'd0);
        default: m_tready <= (sink_cyc[1:0] != 2'd3);
      endcase
    end
  end

  merge_out_t mon_got;
  merge_out_t mon_want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got.rec  = vsrm_pkg::rec_t'(m_tdata[REC_W-1:0]);
      mon_got.sum  = vsrm_pkg::stats_t'(m_tdata[REC_W +: vsrm_pkg::SUM_W]);
      mon_got.tbl  = m_tuser[0];
      mon_got.tend = m_tuser[1];
      mon_got.mend = m_tlast;
      items_checked++;
      if (mon_got.tbl) spill_items++;
      if (merge_results_q.size() == 0) begin
        bad++;
        if (bad <= 10) begin
          $display("unexpected merged item at %0t", $realtime);
          show_item("got ", mon_got);
        end
      end else begin
        mon_want = merge_results_q.pop_front();
        if (mon_got !== mon_want) begin
          bad++;
          if (bad <= 10) begin
            $display("merged item %0d mismatch at %0t", items_checked, $realtime);
            show_item("want", mon_want);
            show_item("got ", mon_got);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [vsrm_pkg::KEY_W-1:0] run_keys[2][$];
    logic [vsrm_pkg::KEY_W-1:0] k;
    logic [vsrm_pkg::KEY_W-1:0] base;
    bit                         big_batch;
    bit                         narrow;
    bit                         unsorted;
    int                         span;
    int                         cnt;
    int                         pos;
    int                         r;

    // empty merge, unused mode
    queue_cmd(vsrm_pkg::MODE_MERGE, '0, '0, '0, '0);
    queue_cmd(MODE_UNUSED, '1, '1, '1, vsrm_pkg::ST_TOMBSTONE);
    // key extremes, version ties and replacements across runs
    queue_cmd(vsrm_pkg::MODE_LOAD_A, vsrm_pkg::KEY_MIN, '0, '0, vsrm_pkg::ST_TOMBSTONE);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, vsrm_pkg::KEY_MIN, rand_val(), 32'd5, ST_UPDATED);
    queue_cmd(vsrm_pkg::MODE_LOAD_A, 32'hFFFF_FFFB, '1, '1, ST_INSERTED);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'hFFFF_FFFB, rand_val(), '0, vsrm_pkg::ST_TOMBSTONE);
    queue_cmd(vsrm_pkg::MODE_LOAD_A, 32'd7, 64'h0123_4567_89AB_CDEF, 32'd3, ST_UPDATED);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'd7, rand_val(), 32'd3, vsrm_pkg::ST_TOMBSTONE);
    queue_cmd(MODE_UNUSED, $urandom, rand_val(), rand_ver(), rand_st());
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'd7, rand_val(), 32'd9, ST_INSERTED);
    queue_cmd(vsrm_pkg::MODE_LOAD_A, vsrm_pkg::KEY_MAX, 64'hFEDC_BA98_7654_3210, 32'd1,
              ST_NONE);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, vsrm_pkg::KEY_MAX, rand_val(), 32'd1,
              vsrm_pkg::ST_TOMBSTONE);
    queue_cmd(vsrm_pkg::MODE_MERGE, $urandom, rand_val(), rand_ver(), rand_st());
    // run b alone, out of order
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'd10, rand_val(), 32'd2, ST_UPDATED);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'd3, rand_val(), 32'd1, ST_INSERTED);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'd3, rand_val(), 32'd4, vsrm_pkg::ST_TOMBSTONE);
    queue_cmd(vsrm_pkg::MODE_LOAD_B, 32'd10, rand_val(), 32'd8, ST_NONE);
    queue_cmd(vsrm_pkg::MODE_MERGE, '0, '0, '0, '0);
    // single record in run a
    queue_cmd(vsrm_pkg::MODE_LOAD_A, 32'h8000_0001, rand_val(), rand_ver(),
              vsrm_pkg::ST_TOMBSTONE);
    queue_cmd(vsrm_pkg::MODE_MERGE, '0, '0, '0, '0);

    while (cmd_q.size() < TARGET) begin
      big_batch = ($urandom_range(0, 4) == 0);
      if (cmd_q.size() > TARGET - 80) big_batch = 1'b0;
      narrow    = !big_batch && ($urandom_range(0, 2) != 0);
      unsorted  = ($urandom_range(0, 9) == 0);
      span      = $urandom_range(1, 12);
      base      = $urandom;
      if ($urandom_range(0, 5) == 0)
        base = ($urandom_range(0, 1) == 1) ? vsrm_pkg::KEY_MIN : vsrm_pkg::KEY_MAX - 12;
      for (r = 0; r < 2; r++) begin
        cnt = big_batch ? $urandom_range(22, 34) : $urandom_range(0, 6);
        for (int n = 0; n < cnt; n++) begin
          k   = narrow ? base + $urandom_range(0, span) : $urandom;
          pos = run_keys[r].size();
          if (!unsorted)
            while (pos > 0 && $signed(run_keys[r][pos-1]) > $signed(k)) pos--;
          run_keys[r].insert(pos, k);
        end
      end
      while (run_keys[0].size() + run_keys[1].size() > 0) begin
        if ($urandom_range(0, 9) == 0)
          queue_cmd(MODE_UNUSED, $urandom, rand_val(), rand_ver(), rand_st());
        if (run_keys[0].size() == 0) r = 1;
        else if (run_keys[1].size() == 0) r = 0;
        else r = $urandom_range(0, 1);
        queue_cmd((r == 0) ? vsrm_pkg::MODE_LOAD_A : vsrm_pkg::MODE_LOAD_B,
                  run_keys[r].pop_front(), rand_val(), rand_ver(), rand_st());
      end
      queue_cmd(vsrm_pkg::MODE_MERGE, $urandom, rand_val(), rand_ver(), rand_st());
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (cmd_q.size() != 0 || merge_results_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);

    $display("%0d commands taken, %0d merges, %0d merged items checked",
             cmds_taken, merges_done, items_checked);
    $display("%0d items went to the second table, %0d mismatches", spill_items, bad);
    if (bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
